[sv/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tensor reduce assertion failed");

// clocked assertion that also holds through reset
`define CHK_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tensor reduce assertion failed");

`endif

[sv/trss_pkg.sv]
// shared widths, register codes, config and control structs for the reduce unit
// no dependencies
package trss_pkg;

  localparam int IDX_W      = 12;
  localparam int VAL_W      = 8;
  localparam int SIZE_W     = 13;
  localparam int RANK_W     = 3;
  localparam int NUM_AXES   = 4;
  localparam int AXIS_W     = 2;
  localparam int SUM_W      = 28;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int DEF_MAX_RANK     = 4;
  localparam int DEF_STORE_DEPTH  = 4096;
  localparam int DEF_ELEMENT_BITS = 8;

  // operation codes of an input transaction
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_RANK        = 3'd0,
    REG_SIZE_0      = 3'd1,
    REG_SIZE_1      = 3'd2,
    REG_SIZE_2      = 3'd3,
    REG_SIZE_3      = 3'd4,
    REG_AXIS_MASK   = 3'd5,
    REG_SIGNED_MODE = 3'd6
  } reg_idx_t;

  localparam logic [RANK_W-1:0]   RST_RANK        = 3'd1;
  localparam logic [SIZE_W-1:0]   RST_SIZE        = 13'd1;
  localparam logic [NUM_AXES-1:0] RST_AXIS_MASK   = 4'hf;
  localparam logic                RST_SIGNED_MODE = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0]               rank;
    logic [NUM_AXES-1:0][SIZE_W-1:0] size;
    logic [NUM_AXES-1:0]             axis_mask;
    logic                            signed_mode;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              query;
    logic              setup_step;
    logic              div_start;
    logic              base_mul;
    logic              base_add;
    logic              walk_init;
    logic              walk_step;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] active;
    logic [NUM_AXES-1:0] reduced;
    logic                total_over;
    logic                index_over;
    logic                red_zero;
    logic                walk_last;
    logic                div_done;
    logic                pipe_empty;
    logic                out_busy;
  } dp_stat_t;

endpackage

[sv/trss_item_if.sv]
// input channel of the reduce unit: valid/ready plus load and query fields
// depends on trss_pkg
interface trss_item_if import trss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [IDX_W-1:0]  element_index;
  logic [VAL_W-1:0]  element_value;
  logic [IDX_W-1:0]  output_index;

  modport source (output valid, op, element_index, element_value, output_index,
                  input ready);
  modport sink   (input valid, op, element_index, element_value, output_index,
                  output ready);
endinterface

[sv/trss_result_if.sv]
// result channel of the reduce unit: valid/ready plus sum and error flag
// depends on trss_pkg
interface trss_result_if import trss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sum_of_squares;
  logic             range_error;

  modport source (output valid, sum_of_squares, range_error, input ready);
  modport sink   (input valid, sum_of_squares, range_error, output ready);
endinterface

[sv/tensor_reduce_sum_square_unit.sv]
// top level of the tensor sum-of-squares reduce unit; uses trss_pkg, the channel
// interfaces, trss_cfg, trss_ctrl and trss_dp. a load is taken every cycle while the unit
// is idle. a query reads its N elements along the reduced axes at one memory read each;
// a kept axis adds a divide and 2 steps, an index or size error skips to the answer,
// and input reopens in the cycle after the result loads.
// reset clears control and config registers; the element memory is not cleared.
module tensor_reduce_sum_square_unit import trss_pkg::*; #(
  parameter int MAX_RANK     = DEF_MAX_RANK,
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  trss_item_if.sink             item,
  trss_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file: the user must write it only while no query is in flight; the block itself does not enforce this
  trss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // controller owns the input handshake; ready only while idle
  // loads are written straight into memory at the accepting edge
  trss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath:
  //   setup   - products of all, kept and reduced sizes plus strides, innermost first
  //   check   - tensor larger than memory or index past the output gives an error
  //   split   - divider peels one kept coordinate per axis, base += coord * stride
  //   walk    - counter over reduced axes issues one read per cycle
  //   drain   - read, square and saturating accumulate pipeline empties
  //   finish  - result loads into the output register once it is free
  trss_dp #(
    .MAX_RANK     (MAX_RANK),
    .STORE_DEPTH  (STORE_DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .element_index  (item.element_index),
    .element_value  (item.element_value),
    .output_index   (item.output_index),
    .result_ready   (result.ready),
    .result_valid   (result.valid),
    .sum_of_squares (result.sum_of_squares),
    .range_error    (result.range_error)
  );

endmodule

[sv/trss_cfg.sv]
// apb register file: rank, axis sizes, axis mask, signed mode
// depends on trss_pkg
module trss_cfg import trss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr;
  reg_idx_t sel;

  assign wr     = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rank        <= RST_RANK;
      cfg.size        <= {NUM_AXES{RST_SIZE}};
      cfg.axis_mask   <= RST_AXIS_MASK;
      cfg.signed_mode <= RST_SIGNED_MODE;
    end else if (wr) begin
      unique case (sel)
        REG_RANK:        cfg.rank        <= pwdata[RANK_W-1:0];
        REG_SIZE_0:      cfg.size[0]     <= pwdata[SIZE_W-1:0];
        REG_SIZE_1:      cfg.size[1]     <= pwdata[SIZE_W-1:0];
        REG_SIZE_2:      cfg.size[2]     <= pwdata[SIZE_W-1:0];
        REG_SIZE_3:      cfg.size[3]     <= pwdata[SIZE_W-1:0];
        REG_AXIS_MASK:   cfg.axis_mask   <= pwdata[NUM_AXES-1:0];
        REG_SIGNED_MODE: cfg.signed_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_RANK:        prdata = APB_DATA_W'(cfg.rank);
      REG_SIZE_0:      prdata = APB_DATA_W'(cfg.size[0]);
      REG_SIZE_1:      prdata = APB_DATA_W'(cfg.size[1]);
      REG_SIZE_2:      prdata = APB_DATA_W'(cfg.size[2]);
      REG_SIZE_3:      prdata = APB_DATA_W'(cfg.size[3]);
      REG_AXIS_MASK:   prdata = APB_DATA_W'(cfg.axis_mask);
      REG_SIGNED_MODE: prdata = APB_DATA_W'(cfg.signed_mode);
      default:         prdata = '0;
    endcase
  end

endmodule

[sv/trss_div.sv]
// restoring divider, one quotient bit per cycle, splits an output index by an axis size
// depends on trss_pkg
module trss_div import trss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic [IDX_W-1:0]  quot,
  output logic [SIZE_W-1:0] remd,
  output logic              done
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]  shifted;
  logic [SIZE_W:0]  diff;
  logic             fits;

  assign shifted = {remd, quot[IDX_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(IDX_W);
        quot <= dividend;
        remd <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        remd <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        quot <= {quot[IDX_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/trss_dp.sv]
// datapath: element memory, shape products, index split, walk counters, square and sum
// depends on trss_pkg and trss_div
module trss_dp import trss_pkg::*; #(
  parameter int MAX_RANK     = DEF_MAX_RANK,
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [IDX_W-1:0]  element_index,
  input  logic [VAL_W-1:0]  element_value,
  input  logic [IDX_W-1:0]  output_index,
  input  logic              result_ready,
  output logic              result_valid,
  output logic [SUM_W-1:0]  sum_of_squares,
  output logic              range_error
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int IMAX  = (1 << IDX_W) - 1;
  localparam int CAP   = (STORE_DEPTH > IMAX ? STORE_DEPTH : IMAX) + 1;
  localparam int CW    = $clog2(CAP + 1);
  localparam int PW    = CW + SIZE_W;
  localparam int RLIM  = MAX_RANK < NUM_AXES ? MAX_RANK : NUM_AXES;
  localparam int SQ_W  = 2 * ELEMENT_BITS;
  localparam int ACC_W = (SQ_W > SUM_W ? SQ_W : SUM_W) + 1;

  // product clamped to CAP, so a size of zero still propagates
  function automatic logic [CW-1:0] sat_mul(input logic [CW-1:0] p,
                                            input logic [SIZE_W-1:0] s);
    logic [PW-1:0] prod;
    prod = PW'(p) * PW'(s);
    if (prod > PW'(CAP)) return CW'(CAP);
    return prod[CW-1:0];
  endfunction

  // shape decode
  logic [RANK_W-1:0]   rank_eff;
  logic [NUM_AXES-1:0] active;
  logic [NUM_AXES-1:0] reduced;

  always_comb begin
    rank_eff = cfg.rank;
    if (rank_eff == '0) rank_eff = RANK_W'(1);
    if (rank_eff > RANK_W'(RLIM)) rank_eff = RANK_W'(RLIM);
    for (int j = 0; j < NUM_AXES; j++) begin
      active[j] = RANK_W'(j) < rank_eff;
    end
    reduced = cfg.axis_mask & active;
    if (reduced == '0) reduced = active;
  end

  // shape products and strides
  logic [CW-1:0]               total_prod;
  logic [CW-1:0]               out_prod;
  logic [CW-1:0]               red_prod;
  logic [NUM_AXES-1:0][CW-1:0] stride;
  logic [SIZE_W-1:0]           sel_size;
  logic [IDX_W-1:0]            idx_q;
  logic [IDX_W-1:0]            rem;
  logic [CW-1:0]               base;
  logic [CW-1:0]               mul_q;
  logic [PW-1:0]               mul_full;

  assign sel_size = cfg.size[cmd.axis];

  // index split
  logic [IDX_W-1:0]  div_quot;
  logic [SIZE_W-1:0] div_remd;
  logic              div_done;

  trss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rem),
    .divisor  (sel_size),
    .quot     (div_quot),
    .remd     (div_remd),
    .done     (div_done)
  );

  assign mul_full = PW'(div_remd) * PW'(stride[cmd.axis]);

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      idx_q      <= output_index;
      rem        <= output_index;
      total_prod <= CW'(1);
      out_prod   <= CW'(1);
      red_prod   <= CW'(1);
      base       <= '0;
    end else if (cmd.setup_step) begin
      stride[cmd.axis] <= total_prod;
      total_prod       <= sat_mul(total_prod, sel_size);
      if (reduced[cmd.axis]) begin
        red_prod <= sat_mul(red_prod, sel_size);
      end else begin
        out_prod <= sat_mul(out_prod, sel_size);
      end
    end else if (cmd.base_mul) begin
      mul_q <= mul_full[CW-1:0];
      rem   <= div_quot;
    end else if (cmd.base_add) begin
      base <= base + mul_q;
    end
  end

  // walk over the reduced axes: mixed-radix counter with per-axis offsets
  logic [NUM_AXES-1:0][SIZE_W-1:0] coord;
  logic [NUM_AXES-1:0][SIZE_W-1:0] coord_next;
  logic [NUM_AXES-1:0][CW-1:0]     offs;
  logic [NUM_AXES-1:0][CW-1:0]     offs_next;
  logic [CW-1:0]                   addr_sum;
  logic [CW-1:0]                   k;
  logic                            carry;

  always_comb begin
    coord_next = coord;
    offs_next  = offs;
    carry      = 1'b1;
    addr_sum   = base;
    for (int j = NUM_AXES - 1; j >= 0; j--) begin
      addr_sum = addr_sum + offs[j];
      if (reduced[j] && carry) begin
        if (coord[j] == cfg.size[j] - SIZE_W'(1)) begin
          coord_next[j] = '0;
          offs_next[j]  = '0;
        end else begin
          coord_next[j] = coord[j] + SIZE_W'(1);
          offs_next[j]  = offs[j] + stride[j];
          carry         = 1'b0;
        end
      end
    end
  end

  // element memory, one write and one registered read per cycle
  logic [ELEMENT_BITS-1:0] mem [STORE_DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    wr_ok;
  logic                    v0;
  logic                    v1;
  logic                    v2;

  assign wr_ok = 32'(element_index) < 32'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) mem[AW'(element_index)] <= ELEMENT_BITS'(element_value);
    if (v0) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      coord <= '0;
      offs  <= '0;
      k     <= '0;
    end else if (cmd.walk_step) begin
      coord   <= coord_next;
      offs    <= offs_next;
      k       <= k + CW'(1);
      rd_addr <= addr_sum[AW-1:0];
    end
  end

  // square and saturating accumulate
  logic                    neg;
  logic [ELEMENT_BITS-1:0] mag;
  logic [SQ_W-1:0]         sq;
  logic [SUM_W-1:0]        acc;
  logic [ACC_W-1:0]        acc_sum;

  assign neg     = cfg.signed_mode && rd_data[ELEMENT_BITS-1];
  assign mag     = neg ? ELEMENT_BITS'(~rd_data + 1'b1) : rd_data;
  assign acc_sum = ACC_W'(acc) + ACC_W'(sq);

  always_ff @(posedge clk) begin
    if (v1) sq <= SQ_W'(mag) * SQ_W'(mag);
    if (cmd.walk_init) begin
      acc <= '0;
    end else if (v2) begin
      acc <= (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.walk_step;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // output register
  logic err;

  assign err = stat.total_over || stat.index_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sum_of_squares <= err ? '0 : acc;
      range_error    <= err;
    end
  end

  // status back to the controller
  assign stat.active     = active;
  assign stat.reduced    = reduced;
  assign stat.total_over = total_prod > CW'(STORE_DEPTH);
  assign stat.index_over = CW'(idx_q) >= out_prod;
  assign stat.red_zero   = red_prod == '0;
  assign stat.walk_last  = k == red_prod - CW'(1);
  assign stat.div_done   = div_done;
  assign stat.pipe_empty = !(v0 || v1 || v2);
  assign stat.out_busy   = result_valid && !result_ready;

endmodule

[sv/trss_ctrl.sv]
// controller: sequences shape setup, index split, element walk and result hand-off
// depends on trss_pkg
module trss_ctrl import trss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_op,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_DECOMP,
    S_DIV_WAIT,
    S_BASE_MUL,
    S_BASE_ADD,
    S_WALK_INIT,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  state_t            state;
  logic [AXIS_W-1:0] axis;
  logic              accept;
  logic              kept_axis;

  assign item_ready = state == S_IDLE;
  assign accept     = item_valid && item_ready;
  assign kept_axis  = stat.active[axis] && !stat.reduced[axis];

  always_comb begin
    cmd       = '0;
    cmd.axis  = axis;
    cmd.load  = accept && item_op == OP_LOAD;
    cmd.query = accept && item_op == OP_QUERY;
    unique case (state)
      S_SETUP:     cmd.setup_step = stat.active[axis];
      S_DECOMP:    cmd.div_start  = kept_axis;
      S_BASE_MUL:  cmd.base_mul   = 1'b1;
      S_BASE_ADD:  cmd.base_add   = 1'b1;
      S_WALK_INIT: cmd.walk_init  = 1'b1;
      S_WALK:      cmd.walk_step  = 1'b1;
      S_FINISH:    cmd.out_load   = !stat.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && item_op == OP_QUERY) begin
            state <= S_SETUP;
            axis  <= AXIS_LAST;
          end
        end
        S_SETUP: begin
          if (axis == '0) state <= S_CHECK;
          else axis <= axis - AXIS_W'(1);
        end
        S_CHECK: begin
          if (stat.total_over || stat.index_over) begin
            state <= S_FINISH;
          end else begin
            state <= S_DECOMP;
            axis  <= AXIS_LAST;
          end
        end
        S_DECOMP: begin
          if (kept_axis) state <= S_DIV_WAIT;
          else if (axis == '0) state <= S_WALK_INIT;
          else axis <= axis - AXIS_W'(1);
        end
        S_DIV_WAIT: begin
          if (stat.div_done) state <= S_BASE_MUL;
        end
        S_BASE_MUL: state <= S_BASE_ADD;
        S_BASE_ADD: begin
          if (axis == '0) begin
            state <= S_WALK_INIT;
          end else begin
            state <= S_DECOMP;
            axis  <= axis - AXIS_W'(1);
          end
        end
        S_WALK_INIT: state <= stat.red_zero ? S_DRAIN : S_WALK;
        S_WALK: begin
          if (stat.walk_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (stat.pipe_empty) state <= S_FINISH;
        end
        S_FINISH: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/trss_checker.sv]
// port-level checks on the reduce unit, bound to the top level
// depends on trss_pkg and assert_macros.svh
`include "assert_macros.svh"

module trss_checker import trss_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             item_op,
  input logic             result_valid,
  input logic             result_ready,
  input logic [SUM_W-1:0] result_sum,
  input logic             result_err
);

  // queries accepted whose result has not been taken yet
  logic [1:0] pending;
  logic       q_acc;
  logic       r_acc;

  assign q_acc = item_valid && item_ready && item_op == OP_QUERY;
  assign r_acc = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(q_acc) - 2'(r_acc);
    end
  end

  `CHK_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid)
  `CHK_ASSERT(a_error_zero, clk, rst, result_valid && result_err |-> result_sum == '0)
  `CHK_ASSERT_NR(a_reset_idle, clk, rst |=> !result_valid)
  `CHK_ASSERT(a_result_owed, clk, rst, result_valid |-> pending != 2'd0)
  `CHK_ASSERT(a_pending_bound, clk, rst, pending != 2'd3)

endmodule

bind tensor_reduce_sum_square_unit trss_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_op      (item.op),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_sum   (result.sum_of_squares),
  .result_err   (result.range_error)
);

[verif/tb_tensor_reduce_sum_square_unit.sv]
// testbench for tensor_reduce_sum_square_unit: loads and queries with an inline
// sum-of-squares predictor, random gaps on both channels. depends on trss_pkg,
// trss_item_if, trss_result_if and the unit itself
`timescale 1ns / 1ps

module tb_tensor_reduce_sum_square_unit import trss_pkg::*; ();

  // cycles to let a trailing load settle before touching the registers
  localparam int SETTLE_CYCLES = 32;
  // low elements loaded up front so directed queries read only loaded entries
  localparam int FILL_COUNT = 128;

  // one expected query answer
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             err;
  } reduce_out_t;

  logic clk = 1'b0;
  logic rst;

  // apb side
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  trss_item_if   item_ch();
  trss_result_if result_ch();

  // predictor state: register shadow and an image of the element memory
  cfg_t             shadow_cfg;
  logic [VAL_W-1:0] element_image [DEF_STORE_DEPTH];
  bit               written [DEF_STORE_DEPTH];
  reduce_out_t      pending_sums [$];

  // idling controls shared by the sender, the ready generator and the tests
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_hold_request = 0;
  int          fail_count = 0;

  tensor_reduce_sum_square_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // gap length: mostly none, often a few cycles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // effective rank, reduced axes and the element / output / reduction counts
  function automatic void shape_of(output int unsigned r, output logic [NUM_AXES-1:0] rm,
                                   output longint unsigned total, output longint unsigned out_cnt,
                                   output longint unsigned red_cnt);
    r = shadow_cfg.rank;
    if (r < 1) r = 1;
    if (r > NUM_AXES) r = NUM_AXES;
    // mask bits past the rank do not count; an empty mask reduces everything
    rm = shadow_cfg.axis_mask & NUM_AXES'((1 << r) - 1);
    if (rm == '0) rm = NUM_AXES'((1 << r) - 1);
    total   = 1;
    out_cnt = 1;
    red_cnt = 1;
    for (int i = 0; i < r; i++) begin
      total = total * shadow_cfg.size[i];
      if (rm[i]) red_cnt = red_cnt * shadow_cfg.size[i];
      else out_cnt = out_cnt * shadow_cfg.size[i];
    end
  endfunction

  // answer of one query under the current shadow registers and memory image;
  // miss is the first element it reads that was never loaded, or -1
  function automatic reduce_out_t predict_sum_of_squares(logic [IDX_W-1:0] oidx,
                                                         output int miss);
    int unsigned         r;
    logic [NUM_AXES-1:0] rm;
    longint unsigned     total, out_cnt, red_cnt, rem, base, off, q, acc, span;
    longint unsigned     stride [NUM_AXES];
    int                  v;
    reduce_out_t         pred;
    miss = -1;
    shape_of(r, rm, total, out_cnt, red_cnt);
    pred.sum = '0;
    pred.err = 1'b1;
    // tensor too large for the memory, or no such output position
    if (total > DEF_STORE_DEPTH || oidx >= out_cnt) return pred;
    // row-major strides, last axis in use fastest
    span = 1;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (i < r) begin
        stride[i] = span;
        span = span * shadow_cfg.size[i];
      end
    end
    // split the output index over the kept axes
    rem  = oidx;
    base = 0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (i < r && !rm[i]) begin
        base = base + (rem % shadow_cfg.size[i]) * stride[i];
        rem  = rem / shadow_cfg.size[i];
      end
    end
    // walk every element along the reduced axes; a zero-size reduced axis walks none
    acc = 0;
    for (longint unsigned k = 0; k < red_cnt; k++) begin
      off = base;
      q   = k;
      for (int i = NUM_AXES - 1; i >= 0; i--) begin
        if (i < r && rm[i]) begin
          off = off + (q % shadow_cfg.size[i]) * stride[i];
          q   = q / shadow_cfg.size[i];
        end
      end
      if (off < DEF_STORE_DEPTH) begin
        if (!written[off] && miss < 0) miss = int'(off);
        v = int'(element_image[off]);
        if (shadow_cfg.signed_mode && element_image[off][VAL_W-1]) v = v - (1 << VAL_W);
        acc = acc + longint'(v * v);
      end
      if (acc > SUM_MAX) acc = SUM_MAX;
    end
    pred.sum = acc[SUM_W-1:0];
    pred.err = 1'b0;
    return pred;
  endfunction

  // one apb write: setup, access, then an idle cycle; the shadow follows the write
  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RANK:        shadow_cfg.rank = value[RANK_W-1:0];
      REG_SIZE_0:      shadow_cfg.size[0] = value[SIZE_W-1:0];
      REG_SIZE_1:      shadow_cfg.size[1] = value[SIZE_W-1:0];
      REG_SIZE_2:      shadow_cfg.size[2] = value[SIZE_W-1:0];
      REG_SIZE_3:      shadow_cfg.size[3] = value[SIZE_W-1:0];
      REG_AXIS_MASK:   shadow_cfg.axis_mask = value[NUM_AXES-1:0];
      REG_SIGNED_MODE: shadow_cfg.signed_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop offering, wait for every outstanding answer, then let a trailing load finish
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full register set, written only once the unit is idle
  task automatic set_shape(logic [RANK_W-1:0] rank, logic [SIZE_W-1:0] s0,
                           logic [SIZE_W-1:0] s1, logic [SIZE_W-1:0] s2,
                           logic [SIZE_W-1:0] s3, logic [NUM_AXES-1:0] mask, logic sgn);
    wait_idle();
    write_reg(REG_RANK,        APB_DATA_W'(rank));
    write_reg(REG_SIZE_0,      APB_DATA_W'(s0));
    write_reg(REG_SIZE_1,      APB_DATA_W'(s1));
    write_reg(REG_SIZE_2,      APB_DATA_W'(s2));
    write_reg(REG_SIZE_3,      APB_DATA_W'(s3));
    write_reg(REG_AXIS_MASK,   APB_DATA_W'(mask));
    write_reg(REG_SIGNED_MODE, APB_DATA_W'(sgn));
  endtask

  // offer one input transaction and record what it does once accepted;
  // valid stays high into the next transaction unless a gap is drawn
  task automatic send_item(logic op, logic [IDX_W-1:0] eidx, logic [VAL_W-1:0] evalue,
                           logic [IDX_W-1:0] oidx);
    int unsigned gap;
    int          miss;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.op            <= op;
    item_ch.element_index <= eidx;
    item_ch.element_value <= evalue;
    item_ch.output_index  <= oidx;
    do @(posedge clk); while (!item_ch.ready);
    if (op == OP_LOAD) begin
      element_image[eidx] = evalue;
      written[eidx]       = 1'b1;
    end else begin
      pending_sums.push_back(predict_sum_of_squares(oidx, miss));
    end
  endtask

  // unused fields of each kind carry random junk
  task automatic load_element(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
    send_item(OP_LOAD, idx, value, IDX_W'($urandom));
  endtask

  // a query that would read a never-loaded element becomes a load of that element
  task automatic query_position(logic [IDX_W-1:0] oidx);
    int miss;
    void'(predict_sum_of_squares(oidx, miss));
    if (miss >= 0) load_element(IDX_W'(miss), VAL_W'($urandom));
    else send_item(OP_QUERY, IDX_W'($urandom), VAL_W'($urandom), oidx);
  endtask

  // result ready: random gaps, plus a long hold-off counted here on request
  initial begin : result_ready_gen
    int unsigned hold;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        hold = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold == 0 && rx_idle_on) hold = pick_gap();
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // every result transaction is matched against the oldest expected answer
  always @(posedge clk) begin
    reduce_out_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_sums.size() == 0) begin
        $error("result with no query outstanding: sum_of_squares %0d range_error %0b",
               result_ch.sum_of_squares, result_ch.range_error);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        if (result_ch.sum_of_squares !== want.sum) begin
          $error("sum_of_squares: expected %0d, got %0d", want.sum, result_ch.sum_of_squares);
          fail_count++;
        end
        if (result_ch.range_error !== want.err) begin
          $error("range_error: expected %0b, got %0b", want.err, result_ch.range_error);
          fail_count++;
        end
      end
    end
  end

  // reset values: rank 1, unit sizes, so a single element answers position 0 and other positions give a range error
  task automatic test_reset_defaults();
    load_element('0, 8'h80);
    query_position('0);
    query_position(IDX_W'(1));
    query_position('1);
  endtask

  // low block of memory written once for the directed queries, then the far end
  // of memory, largest element values, largest tensor and largest output index
  task automatic test_field_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < FILL_COUNT; i++) load_element(IDX_W'(i), VAL_W'($urandom));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    load_element('1, 8'hff);
    load_element('0, 8'h00);
    load_element(IDX_W'(1), 8'h7f);
    load_element(IDX_W'(2), 8'h80);
    // one 128-element sum, as signed then unsigned bytes
    set_shape(3'd1, 13'd128, 13'd1, 13'd1, 13'd1, 4'b0001, 1'b1);
    query_position('0);
    set_shape(3'd1, 13'd128, 13'd1, 13'd1, 13'd1, 4'b0001, 1'b0);
    query_position('0);
    // 4096 output positions, one element each: last index is in range
    set_shape(3'd2, 13'd4096, 13'd1, 13'd1, 13'd1, 4'b0010, 1'b0);
    query_position('1);
    query_position('0);
    query_position(IDX_W'(2));
  endtask

  task automatic test_special_cases();
    // rank 0 counts as 1; empty mask reduces everything, one output position
    set_shape(3'd0, 13'd16, 13'd3, 13'd3, 13'd3, 4'b0000, 1'b1);
    query_position('0);
    query_position(IDX_W'(1));
    // rank above 4 clamps to 4; axes 0 and 3 kept, 10 positions
    set_shape(3'd7, 13'd2, 13'd3, 13'd4, 13'd5, 4'b0110, 1'b1);
    query_position(IDX_W'(9));
    query_position(IDX_W'(10));
    // mask bits beyond the rank only: same as an empty mask
    set_shape(3'd2, 13'd5, 13'd6, 13'd7, 13'd7, 4'b1100, 1'b0);
    query_position('0);
    // tensor larger than the memory, rank 3 and a single oversized axis
    set_shape(3'd3, 13'd16, 13'd16, 13'd17, 13'd1, 4'b0100, 1'b1);
    query_position('0);
    set_shape(3'd1, 13'd8191, 13'd1, 13'd1, 13'd1, 4'b0001, 1'b1);
    query_position('0);
    // zero-size reduced axis: answered, sum of nothing
    set_shape(3'd2, 13'd0, 13'd4, 13'd1, 13'd1, 4'b0001, 1'b1);
    query_position(IDX_W'(3));
    // zero-size kept axis: no output position exists
    set_shape(3'd2, 13'd4, 13'd0, 13'd1, 13'd1, 4'b0001, 1'b1);
    query_position('0);
  endtask

  // results held off long enough for the unit to fill and stall its input,
  // then the sender pauses until everything has come back
  task automatic test_backpressure();
    set_shape(3'd2, 13'd8, 13'd8, 13'd1, 13'd1, 4'b0010, 1'b1);
    tx_idle_on = 1'b0;
    rx_hold_request = 400;
    for (int n = 0; n < 16; n++) begin
      if (n % 4 == 3) load_element(IDX_W'($urandom_range(0, 63)), VAL_W'($urandom));
      else query_position(IDX_W'($urandom_range(0, 7)));
    end
    wait_idle();
    tx_idle_on = 1'b1;
    for (int n = 0; n < 12; n++) query_position(IDX_W'($urandom_range(0, 8)));
  endtask

  // extent of one axis: mostly small, sometimes zero, now and then anything
  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 2) return '0;
    if (p < 3) return SIZE_W'($urandom);
    if (p < 6) return SIZE_W'($urandom_range(5, 16));
    return SIZE_W'($urandom_range(1, 4));
  endfunction

  task automatic test_random_shapes();
    int unsigned         r;
    logic [NUM_AXES-1:0] rm;
    longint unsigned     total, out_cnt, red_cnt, cap;
    logic [RANK_W-1:0]   rank;
    logic [IDX_W-1:0]    idx;
    for (int phase = 0; phase < 8; phase++) begin
      rank = ($urandom_range(0, 4) == 0) ? RANK_W'($urandom) : RANK_W'($urandom_range(1, 4));
      set_shape(rank, random_size(), random_size(), random_size(), random_size(),
                NUM_AXES'($urandom), 1'($urandom));
      // some phases run with no idling at all on one side or both
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      shape_of(r, rm, total, out_cnt, red_cnt);
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          // loads mostly land inside the tensor so later queries see them
          if (total >= 1 && total <= DEF_STORE_DEPTH && $urandom_range(0, 3) != 0)
            idx = IDX_W'($urandom_range(0, int'(total) - 1));
          else
            idx = IDX_W'($urandom);
          load_element(idx, VAL_W'($urandom));
        end else begin
          cap = (out_cnt > DEF_STORE_DEPTH) ? DEF_STORE_DEPTH : out_cnt;
          if (cap >= 1 && total <= DEF_STORE_DEPTH && $urandom_range(0, 4) != 0)
            idx = IDX_W'($urandom_range(0, int'(cap) - 1));
          else
            idx = IDX_W'($urandom);
          query_position(idx);
        end
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.op            <= OP_LOAD;
    item_ch.element_index <= '0;
    item_ch.element_value <= '0;
    item_ch.output_index  <= '0;
    shadow_cfg.rank        = RST_RANK;
    shadow_cfg.size        = {NUM_AXES{RST_SIZE}};
    shadow_cfg.axis_mask   = RST_AXIS_MASK;
    shadow_cfg.signed_mode = RST_SIGNED_MODE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_backpressure();
    test_random_shapes();

    wait_idle();
    if (fail_count == 0) begin
      $display("** tensor_reduce_sum_square_unit: PASSED **");
    end else begin
      $display("** tensor_reduce_sum_square_unit: FAILED **");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #40_000_000;
    $display("** tensor_reduce_sum_square_unit: FAILED **");
    $finish;
  end

endmodule
